// File: rtl/jsdm_pkg.sv
// Shared constants, types and helpers for the joystick slew and drive mix block.
package jsdm_pkg;

  localparam int FRAC_BITS = 8;
  localparam int LIM       = 100 << FRAC_BITS;  // full throw
  localparam int SCALE     = 500 << FRAC_BITS;  // wheel value scaling

  localparam int MW      = 27;      // multiplier operand width
  localparam int PW      = 2 * MW;  // product width
  localparam int NUM_W   = 32;      // divider dividend width
  localparam int DEN_W   = 26;      // divider divisor width
  localparam int SQ_W    = 34;      // sum of squares width
  localparam int ROOT_W  = SQ_W / 2;

  // floor(n / 100) == (n * RECIP100) >> RECIP_SH for n up to 10000
  localparam int RECIP100 = 5243;
  localparam int RECIP_SH = 19;

  typedef enum logic [2:0] {
    CFG_SPEED, CFG_ACT, CFG_PH_ACC, CFG_PH_DEC, CFG_ST_ACC, CFG_ST_DEC
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_ACC, ST_SQRT, ST_DIV, ST_LN, ST_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_SX2, OP_SY2, OP_EX2, OP_EY2, OP_DX2, OP_DY2, OP_MAG2, OP_SLEWX,
    OP_SLEWY, OP_SETACT, OP_FWD, OP_YF, OP_XR, OP_FLIM, OP_LEFT, OP_RIGHT
  } op_e;

  localparam logic [1:0] MODE_PHONE = 2'd1;

  function automatic logic [6:0] set_pct(input logic [1:0] s);
    unique case (s)
      2'd0:    set_pct = 7'd40;
      2'd1:    set_pct = 7'd70;
      default: set_pct = 7'd100;
    endcase
  endfunction

endpackage

// File: rtl/joystick_slew_differential_drive_mix_unit.sv
// Top level: joystick slew limiter and differential drive mixer.
//
// Input stream (s_axis): one joystick position and the system mode per
// transaction. Output stream (m_axis): one left/right wheel command pair per
// input transaction, in order.
// Config port: cfg_we_i writes cfg_data_i to register cfg_idx_i; unknown
// indexes are dropped. Write only while the block is idle.
// One item is in work at a time. Its processing time is set by the
// bit-serial divider (up to four divisions per item), the square root and
// one shared multiplier stepped through up to 16 products, and is shorter
// when the stored vector snaps to the target.
// The result sits in an output register; the next item is taken while it
// waits. If the receiver stalls, a second finished result holds the block
// until the first is taken.
// Reset clears the stored vector to zero, loads the register defaults and
// leaves the output empty.
module joystick_slew_differential_drive_mix_unit import jsdm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // pos_x[15:0], pos_y[31:16], sys_mode[33:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // left_speed[7:0], right_speed[15:8]
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [14:0] cfg_data_i
);

  // configuration
  logic [1:0]  speed_q;
  logic [6:0]  act_q;
  logic [14:0] ph_acc_q, ph_dec_q, st_acc_q, st_dec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q  <= 2'd1;
      act_q    <= 7'd100;
      ph_acc_q <= 15'd1024;
      ph_dec_q <= 15'd2560;
      st_acc_q <= 15'd2560;
      st_dec_q <= 15'd3840;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SPEED:  speed_q  <= cfg_data_i[1:0];
        CFG_ACT:    act_q    <= cfg_data_i[6:0];
        CFG_PH_ACC: ph_acc_q <= cfg_data_i;
        CFG_PH_DEC: ph_dec_q <= cfg_data_i;
        CFG_ST_ACC: st_acc_q <= cfg_data_i;
        CFG_ST_DEC: st_dec_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;
  op_e    op_q, op_d;

  logic signed [15:0]   sx_q, sy_q, ex_q, ey_q;
  logic signed [16:0]   dx_q, dy_q;
  logic [1:0]           mode_q;
  logic signed [PW-1:0] p_q;
  logic [SQ_W-1:0]      s2_q, e2_q, d2_q;
  logic [ROOT_W-1:0]    len_q;
  logic [13:0]          n_q;
  logic [6:0]           fwd_q;
  logic [3:0]           rot_q;
  logic signed [MW-1:0] yf_q, xr_q, ln_q, rn_q;
  logic                 big_q, neg_q;
  logic signed [7:0]    left_q, right_q;
  logic                 m_valid_q;
  logic [15:0]          m_data_q;

  logic                 accept, out_load;
  logic                 sqrt_start, sqrt_done, div_start, div_done;
  logic [ROOT_W-1:0]    root;
  logic [NUM_W-1:0]     quo;

  // input saturation
  logic signed [23:0] px, py;
  logic signed [15:0] ex_sat, ey_sat;
  assign px = 24'(signed'(s_axis_tdata[15:0]));
  assign py = 24'(signed'(s_axis_tdata[31:16]));
  always_comb begin
    ex_sat = px[15:0];
    ey_sat = py[15:0];
    if (px > 24'(LIM))  ex_sat = 16'(LIM);
    if (px < -24'(LIM)) ex_sat = 16'(-LIM);
    if (py > 24'(LIM))  ey_sat = 16'(LIM);
    if (py < -24'(LIM)) ey_sat = 16'(-LIM);
  end

  // step length: accelerate when the target is longer, decelerate when shorter, zero when equal
  logic [14:0] acc_step, dec_step, mag;
  assign acc_step = (mode_q == MODE_PHONE) ? ph_acc_q : st_acc_q;
  assign dec_step = (mode_q == MODE_PHONE) ? ph_dec_q : st_dec_q;
  assign mag = (e2_q > s2_q) ? acc_step : ((e2_q < s2_q) ? dec_step : '0);

  logic [6:0]  act_sat;
  assign act_sat = (act_q > 7'd100) ? 7'd100 : act_q;

  // rotation limit from |y|
  logic [16:0] abs_sy;
  logic [23:0] rr;
  logic [26:0] r5;
  logic [9:0]  tt;
  logic [3:0]  rot_calc;
  assign abs_sy = sy_q[15] ? 17'(-18'(sy_q)) : 17'(sy_q);
  assign rr = 24'(LIM) - 24'(abs_sy);
  assign r5 = {rr, 2'b00} + 27'(rr);
  assign tt = 10'(r5 >> FRAC_BITS);
  assign rot_calc = 4'd3 + 4'(tt >= 10'd100) + 4'(tt >= 10'd200) + 4'(tt >= 10'd300)
                  + 4'(tt >= 10'd400) + 4'(tt >= 10'd500);

  // larger wheel magnitude
  logic [MW-1:0] abs_ln, abs_rn, m_max;
  logic          big_calc, snap;
  assign abs_ln   = ln_q[MW-1] ? MW'(-ln_q) : MW'(ln_q);
  assign abs_rn   = rn_q[MW-1] ? MW'(-rn_q) : MW'(rn_q);
  assign m_max    = (abs_ln > abs_rn) ? abs_ln : abs_rn;
  assign big_calc = {{(PW-MW){1'b0}}, m_max} > $unsigned(p_q);
  assign snap     = p_q[SQ_W-1:0] >= d2_q;

  // shared multiplier
  logic signed [MW-1:0] ma, mb;
  always_comb begin
    unique case (op_q)
      OP_SX2:    begin ma = MW'(sx_q); mb = MW'(sx_q); end
      OP_SY2:    begin ma = MW'(sy_q); mb = MW'(sy_q); end
      OP_EX2:    begin ma = MW'(ex_q); mb = MW'(ex_q); end
      OP_EY2:    begin ma = MW'(ey_q); mb = MW'(ey_q); end
      OP_DX2:    begin ma = MW'(dx_q); mb = MW'(dx_q); end
      OP_DY2:    begin ma = MW'(dy_q); mb = MW'(dy_q); end
      OP_MAG2:   begin ma = MW'(signed'({1'b0, mag})); mb = MW'(signed'({1'b0, mag})); end
      OP_SLEWX:  begin ma = MW'(dx_q); mb = MW'(signed'({1'b0, mag})); end
      OP_SLEWY:  begin ma = MW'(dy_q); mb = MW'(signed'({1'b0, mag})); end
      OP_SETACT: begin
        ma = MW'(signed'({1'b0, set_pct(speed_q)}));
        mb = MW'(signed'({1'b0, act_sat}));
      end
      OP_FWD:    begin ma = MW'(signed'({1'b0, n_q})); mb = MW'(RECIP100); end
      OP_YF:     begin ma = MW'(sy_q); mb = MW'(signed'({1'b0, fwd_q})); end
      OP_XR:     begin ma = MW'(sx_q); mb = MW'(signed'({1'b0, rot_q})); end
      OP_FLIM:   begin ma = MW'(signed'({1'b0, fwd_q})); mb = MW'(SCALE); end
      OP_LEFT:   begin ma = ln_q; mb = MW'(signed'({1'b0, fwd_q})); end
      OP_RIGHT:  begin ma = rn_q; mb = MW'(signed'({1'b0, fwd_q})); end
      default:   begin ma = '0; mb = '0; end
    endcase
  end

  // divider operands: sign stripped here, restored on the quotient
  logic signed [PW-1:0] num_s;
  logic [PW-1:0]        num_abs;
  logic [DEN_W-1:0]     den;
  always_comb begin
    num_s = p_q;
    den   = DEN_W'(len_q);
    if ((op_q == OP_LEFT || op_q == OP_RIGHT) && !big_q) begin
      num_s = (op_q == OP_LEFT) ? PW'(ln_q) : PW'(rn_q);
      den   = DEN_W'(SCALE);
    end else if (op_q == OP_LEFT || op_q == OP_RIGHT) begin
      den   = m_max[DEN_W-1:0];
    end
    num_abs = num_s[PW-1] ? PW'(-num_s) : PW'(num_s);
  end

  // control
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_SX2;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    s_axis_tready = 1'b0;
    sqrt_start    = 1'b0;
    div_start     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          op_d    = OP_SX2;
          state_d = ST_MUL;
        end
      end
      ST_MUL: state_d = ST_ACC;
      ST_ACC: begin
        priority case (op_q)
          OP_MAG2: begin
            if (snap) begin
              op_d    = OP_SETACT;
              state_d = mode_q[1] ? ST_OUT : ST_MUL;
            end else begin
              sqrt_start = 1'b1;
              state_d    = ST_SQRT;
            end
          end
          OP_SLEWX, OP_SLEWY, OP_LEFT, OP_RIGHT: begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end
          OP_XR: state_d = ST_LN;
          OP_FLIM: begin
            op_d    = OP_LEFT;
            state_d = big_calc ? ST_MUL : ST_ACC;
          end
          default: begin
            op_d    = op_e'(op_q + 4'd1);
            state_d = ST_MUL;
          end
        endcase
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          op_d    = OP_SLEWX;
          state_d = ST_MUL;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          priority case (op_q)
            OP_SLEWX: begin
              op_d    = OP_SLEWY;
              state_d = ST_MUL;
            end
            OP_SLEWY: begin
              op_d    = OP_SETACT;
              state_d = mode_q[1] ? ST_OUT : ST_MUL;
            end
            OP_LEFT: begin
              op_d    = OP_RIGHT;
              state_d = big_q ? ST_MUL : ST_ACC;
            end
            default: state_d = ST_OUT;
          endcase
        end
      end
      ST_LN: begin
        op_d    = OP_FLIM;
        state_d = ST_MUL;
      end
      ST_OUT: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // stored vector
  logic signed [17:0] qv, step;
  assign qv   = signed'({1'b0, quo[16:0]});
  assign step = neg_q ? -qv : qv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q <= '0;
      sy_q <= '0;
    end else if (state_q == ST_ACC && op_q == OP_MAG2 && snap) begin
      sx_q <= ex_q;
      sy_q <= ey_q;
    end else if (state_q == ST_DIV && div_done && op_q == OP_SLEWX) begin
      sx_q <= 16'(18'(sx_q) + step);
    end else if (state_q == ST_DIV && div_done && op_q == OP_SLEWY) begin
      sy_q <= 16'(18'(sy_q) + step);
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ex_q   <= ex_sat;
      ey_q   <= ey_sat;
      dx_q   <= 17'(ex_sat) - 17'(sx_q);
      dy_q   <= 17'(ey_sat) - 17'(sy_q);
      mode_q <= s_axis_tdata[33:32];
    end
    if (state_q == ST_MUL) p_q <= ma * mb;
    if (sqrt_done) len_q <= root;
    if (state_q == ST_LN) begin
      ln_q <= yf_q + xr_q;
      rn_q <= yf_q - xr_q;
    end
    if (state_q == ST_DIV && div_done && op_q == OP_LEFT)
      left_q <= neg_q ? -quo[7:0] : quo[7:0];
    if (state_q == ST_DIV && div_done && op_q == OP_RIGHT)
      right_q <= neg_q ? -quo[7:0] : quo[7:0];
    if (state_q == ST_ACC) begin
      unique case (op_q)
        OP_SX2:    s2_q <= p_q[SQ_W-1:0];
        OP_SY2:    s2_q <= s2_q + p_q[SQ_W-1:0];
        OP_EX2:    e2_q <= p_q[SQ_W-1:0];
        OP_EY2:    e2_q <= e2_q + p_q[SQ_W-1:0];
        OP_DX2:    d2_q <= p_q[SQ_W-1:0];
        OP_DY2:    d2_q <= d2_q + p_q[SQ_W-1:0];
        OP_SETACT: n_q  <= p_q[13:0];
        OP_FWD: begin
          fwd_q <= p_q[RECIP_SH+6:RECIP_SH];
          rot_q <= rot_calc;
        end
        // reverse runs at 2/5 of forward
        OP_YF:     yf_q <= sy_q[15] ? MW'(p_q <<< 1) : MW'((p_q <<< 2) + p_q);
        OP_XR:     xr_q <= MW'((p_q <<< 2) + p_q);
        OP_FLIM:   big_q <= big_calc;
        OP_SLEWX, OP_SLEWY, OP_LEFT, OP_RIGHT: neg_q <= num_s[PW-1];
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) m_data_q <= mode_q[1] ? 16'h0000 : {-right_q, left_q};
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  jsdm_sqrt #(.IW(SQ_W)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .val_i   (d2_q),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  jsdm_div #(.NW(NUM_W), .DW(DEN_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_abs[NUM_W-1:0]),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // one item at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  // stored vector stays within full throw
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (24'(sx_q) <= 24'(LIM)) && (24'(sx_q) >= -24'(LIM))
    && (24'(sy_q) <= 24'(LIM)) && (24'(sy_q) >= -24'(LIM)))
    else $error("stored vector beyond full throw");

  // divider and root only finish while the sequencer waits for them
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside its wait state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> state_q == ST_SQRT)
    else $error("square root finished outside its wait state");

endmodule

// File: rtl/jsdm_div.sv
// Restoring divider, one quotient bit per cycle.
module jsdm_div import jsdm_pkg::*; #(
  parameter int NW = NUM_W,
  parameter int DW = DEN_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);
  localparam int CW = $clog2(NW);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] rem_q, den_q;
  logic [NW-1:0] quo_q;
  logic [DW:0]   sh;
  logic          ge;

  assign sh = {rem_q, quo_q[NW-1]};
  assign ge = sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? DW'(sh - {1'b0, den_q}) : DW'(sh);
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: rtl/jsdm_sqrt.sv
// Integer square root, two radicand bits per cycle.
module jsdm_sqrt import jsdm_pkg::*; #(
  parameter int IW = SQ_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [IW-1:0]     val_i,
  output logic              done_o,
  output logic [IW/2-1:0]   root_o
);
  localparam int RW = IW / 2;
  localparam int CW = $clog2(RW);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [IW-1:0] val_q;
  logic [RW-1:0] root_q;
  logic [RW+1:0] rem_q;
  logic [RW+3:0] sh, trial;
  logic          ge;

  assign sh    = {rem_q, val_q[IW-1:IW-2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign ge    = sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(RW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= val_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      val_q  <= {val_q[IW-3:0], 2'b00};
      rem_q  <= ge ? (RW+2)'(sh - trial) : (RW+2)'(sh);
      root_q <= {root_q[RW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// File: verif/joystick_slew_differential_drive_mix_unit_tb.sv
// Testbench for the joystick slew limiter and differential drive mixer.
`timescale 1ns / 1ps

module joystick_slew_differential_drive_mix_unit_tb;
  import jsdm_pkg::*;

  typedef struct {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [1:0]         sys_mode;
  } joy_item_t;

  typedef struct {
    logic signed [7:0] left_speed;
    logic signed [7:0] right_speed;
  } wheel_cmd_t;

  localparam longint LIM_Q   = 100 << FRAC_BITS;
  localparam longint SCALE_Q = 500 << FRAC_BITS;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // pos_x, pos_y, sys_mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;       // left_speed, right_speed
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [14:0] cfg_data_i = '0;

  joystick_slew_differential_drive_mix_unit u_top (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  longint    speed_sel, act_pct, ph_acc, ph_dec, st_acc, st_dec;
  longint    glide_x, glide_y;
  joy_item_t pending_q[$];
  wheel_cmd_t wheel_q[$];
  int        n_errors = 0;
  bit        hold_off = 1'b0;
  int        hold_cnt = 0;
  bit        stim_done = 1'b0;

  function automatic longint iroot(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 60;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else r = r >>> 1;
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint clampq(longint v);
    return (v > LIM_Q) ? LIM_Q : ((v < -LIM_Q) ? -LIM_Q : v);
  endfunction

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic wheel_cmd_t mix_wheels(joy_item_t it);
    wheel_cmd_t w;
    longint tx, ty, acc, dec, s2, e2, mag, dx, dy, d2, len;
    longint setp, act, fwd, ay, rot, a, ln, rn, m, lf, rt;
    tx = clampq(longint'(it.pos_x));
    ty = clampq(longint'(it.pos_y));
    acc = (it.sys_mode == MODE_PHONE) ? ph_acc : st_acc;
    dec = (it.sys_mode == MODE_PHONE) ? ph_dec : st_dec;
    s2 = glide_x * glide_x + glide_y * glide_y;
    e2 = tx * tx + ty * ty;
    mag = (e2 > s2) ? acc : ((e2 < s2) ? dec : 0);
    dx = tx - glide_x;
    dy = ty - glide_y;
    d2 = dx * dx + dy * dy;
    if (mag * mag >= d2) begin
      glide_x = tx;
      glide_y = ty;
    end else begin
      len = iroot(d2);
      glide_x = clampq(glide_x + dx * mag / len);
      glide_y = clampq(glide_y + dy * mag / len);
    end
    lf = 0;
    rt = 0;
    if (it.sys_mode <= 2'd1) begin
      setp = (speed_sel == 0) ? 40 : ((speed_sel == 1) ? 70 : 100);
      act = act_pct > 100 ? 100 : act_pct;
      fwd = setp * act / 100;
      ay = absl(glide_y);
      if (ay > LIM_Q) ay = LIM_Q;
      rot = 3 + (5 * (LIM_Q - ay)) / LIM_Q;
      a = (glide_y < 0) ? 2 : 5;
      ln = a * glide_y * fwd + 5 * glide_x * rot;
      rn = a * glide_y * fwd - 5 * glide_x * rot;
      m = absl(ln) > absl(rn) ? absl(ln) : absl(rn);
      if (m > fwd * SCALE_Q) begin
        lf = ln * fwd / m;
        rt = rn * fwd / m;
      end else begin
        lf = ln / SCALE_Q;
        rt = rn / SCALE_Q;
      end
      rt = -rt;
    end
    w.left_speed = lf[7:0];
    w.right_speed = rt[7:0];
    return w;
  endfunction

  // handshake seen at the rising edge
  logic s_axis_tready_q = 1'b0;
  always @(posedge clk_i) s_axis_tready_q <= s_axis_tvalid && s_axis_tready;

  // driver: bursts with random gaps
  int gap_left = 0, burst_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready_q) begin
        wheel_q.push_back(mix_wheels(pending_q.pop_front()));
      end
      if (s_axis_tvalid && !s_axis_tready_q) begin
        // hold item
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'b0, pending_q[0].sys_mode, pending_q[0].pos_y, pending_q[0].pos_x};
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 200);
        end else burst_left <= burst_left - 1;
      end else s_axis_tvalid <= 1'b0;
    end
  end

  // monitor and receiver stall pattern
  always @(posedge clk_i) begin
    wheel_cmd_t exp_w, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.left_speed = m_axis_tdata[7:0];
      got.right_speed = m_axis_tdata[15:8];
      if (wheel_q.size() == 0) begin
        $display("%0t: unexpected transaction left %0d right %0d", $time,
                 got.left_speed, got.right_speed);
        n_errors++;
      end else begin
        exp_w = wheel_q.pop_front();
        if (got.left_speed !== exp_w.left_speed) begin
          $display("%0t: left_speed expected %0d actual %0d", $time,
                   exp_w.left_speed, got.left_speed);
          n_errors++;
        end
        if (got.right_speed !== exp_w.right_speed) begin
          $display("%0t: right_speed expected %0d actual %0d", $time,
                   exp_w.right_speed, got.right_speed);
          n_errors++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_off) begin
      m_axis_tready <= 1'b0;
      if (hold_cnt < 3000) hold_cnt <= hold_cnt + 1;
    end else if (stim_done) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0) || ($time % 20000 < 5000);
  end

  task automatic write_reg(cfg_idx_e idx, logic [14:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SPEED:  speed_sel = val & 15'h3;
      CFG_ACT:    act_pct = val & 15'h7f;
      CFG_PH_ACC: ph_acc = val;
      CFG_PH_DEC: ph_dec = val;
      CFG_ST_ACC: st_acc = val;
      default:    st_dec = val;
    endcase
  endtask

  task automatic add_item(logic [15:0] x, logic [15:0] y, logic [1:0] md);
    joy_item_t it;
    it.pos_x = x;
    it.pos_y = y;
    it.sys_mode = md;
    pending_q.push_back(it);
  endtask

  function automatic logic [15:0] rand_pos();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom());
      1:       return $urandom_range(0, 1) ? 16'sd25600 : -16'sd25600;
      default: return 16'($signed($urandom_range(0, 51200)) - 25600);
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_q.size() > 0 || s_axis_tvalid || wheel_q.size() > 0)
      @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic random_phase(int n);
    logic [15:0] x, y;
    for (int i = 0; i < n; i++) begin
      // mostly repeated targets so the slew has time to settle
      if ($urandom_range(0, 3) == 0 || i == 0) begin
        x = rand_pos();
        y = rand_pos();
      end
      add_item(x, y, ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3))
                                                  : 2'($urandom_range(0, 1)));
    end
    wait_drained();
  endtask

  initial begin
    speed_sel = 1; act_pct = 100; ph_acc = 1024; ph_dec = 2560;
    st_acc = 2560; st_dec = 3840;
    glide_x = 0; glide_y = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed: extremes, modes, saturation, equal lengths
    add_item(16'sd25600, 16'sd0, 2'd0);
    add_item(16'sd0, 16'sd25600, 2'd0);
    add_item(16'sd0, 16'sd25600, 2'd0);
    add_item(16'sd32767, -16'sd32768, 2'd1);
    add_item(-16'sd32768, 16'sd32767, 2'd1);
    add_item(16'sd25600, 16'sd0, 2'd2);
    add_item(16'sd0, 16'sd25600, 2'd3);
    add_item(-16'sd25600, -16'sd25600, 2'd0);
    add_item(16'sd0, 16'sd0, 2'd0);
    add_item(16'sd0, 16'sd0, 2'd1);
    add_item(16'hffff, 16'h0001, 2'd0);
    wait_drained();

    write_reg(CFG_SPEED, 15'd0);
    write_reg(CFG_ACT, 15'd1);
    write_reg(CFG_PH_ACC, 15'd0);
    write_reg(CFG_PH_DEC, 15'd25600);
    write_reg(CFG_ST_ACC, 15'd25600);
    write_reg(CFG_ST_DEC, 15'd0);
    random_phase(60);

    write_reg(CFG_SPEED, 15'd2);
    write_reg(CFG_ACT, 15'd100);
    write_reg(CFG_PH_ACC, 15'h7fff);
    write_reg(CFG_ST_DEC, 15'h7fff);
    random_phase(60);

    write_reg(CFG_SPEED, 15'd3);
    write_reg(CFG_ACT, 15'h7f);
    write_reg(CFG_PH_DEC, 15'd300);
    write_reg(CFG_ST_ACC, 15'd700);
    write_reg(CFG_ST_DEC, 15'd900);
    hold_off = 1'b1;
    random_phase(0);
    for (int i = 0; i < 10; i++) add_item(rand_pos(), rand_pos(), 2'd0);
    while (hold_cnt < 3000) @(posedge clk_i);
    hold_off = 1'b0;
    wait_drained();

    write_reg(CFG_ACT, 15'd0);
    random_phase(30);

    write_reg(CFG_SPEED, 15'd1);
    write_reg(CFG_ACT, 15'd55);
    write_reg(CFG_PH_ACC, 15'd1024);
    write_reg(CFG_PH_DEC, 15'd2560);
    write_reg(CFG_ST_ACC, 15'd2560);
    write_reg(CFG_ST_DEC, 15'd3840);
    random_phase(240);

    stim_done = 1'b1;
    if (n_errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #8000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/jsdm_pkg.sv
rtl/jsdm_div.sv
rtl/jsdm_sqrt.sv
rtl/joystick_slew_differential_drive_mix_unit.sv
verif/joystick_slew_differential_drive_mix_unit_tb.sv
